>>> hdl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Included by every module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/h4dfr_pkg.sv
// Package for the H4 deframer: widths, packet kind codes, register map,
// queue entry type. No dependencies.
`timescale 1ns / 1ps

package h4dfr_pkg;

  localparam int DATA_W  = 8;
  localparam int KIND_W  = 3;
  localparam int FLEN_W  = 11;
  localparam int LEN_W   = 17;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 2;
  localparam int PDATA_W = 32;
  localparam int BURST_N = 4;
  localparam int IDX_W   = 2;

  localparam int MAX_FRAME_DEF   = 1024;
  localparam int QUEUE_DEPTH_DEF = 5;

  localparam logic [CFG_W-1:0]  MAX_DELIVER_RST = 16'd512;
  localparam logic [ADDR_W-1:0] REG_MAX_DELIVER = 2'd0;

  localparam logic [KIND_W-1:0] KIND_CMD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ISO = 3'd5;

  // one queue entry: a header burst of 2..4 bytes or a single payload byte
  typedef struct packed {
    logic [KIND_W-1:0]              kind;
    logic [FLEN_W-1:0]              length;
    logic [IDX_W-1:0]               last_idx;
    logic                           first;
    logic                           last;
    logic [BURST_N-1:0][DATA_W-1:0] bytes;
  } entry_t;

endpackage

>>> hdl/h4dfr_front.sv
// Front end of the H4 deframer: hunts for indicators, collects the header,
// works out the frame length and pushes header bursts and payload bytes.
// Depends on h4dfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h4dfr_front import h4dfr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_rx_byte,
  input  logic [CFG_W-1:0]  max_deliver,
  input  logic              full,
  output logic              push,
  output entry_t            push_data
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HDR  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [KIND_W-1:0]            kind_r, kind_nxt;
  logic [CNT_W-1:0]             rcv_r, rcv_nxt;
  logic [CNT_W-1:0]             need_r, need_nxt;
  logic                         swallow_r, swallow_nxt;
  logic [2:0][DATA_W-1:0]       hold_r;
  logic                         acc;
  logic                         hdr_done;
  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             need_ext;
  logic [IDX_W-1:0]             burst_last;
  logic                         done;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;
  assign need_ext = LEN_W'(need_r);

  always_comb begin
    rcv_nxt = (rcv_r < CNT_W'(MAX_FRAME)) ? rcv_r + 1'b1 : rcv_r;
    case (kind_r)
      KIND_CMD, KIND_SCO: begin
        hdr_done   = (rcv_nxt == CNT_W'(3));
        len        = LEN_W'(3) + LEN_W'(in_rx_byte);
        burst_last = IDX_W'(2);
      end
      KIND_EVT: begin
        hdr_done   = (rcv_nxt == CNT_W'(2));
        len        = LEN_W'(2) + LEN_W'(in_rx_byte);
        burst_last = IDX_W'(1);
      end
      KIND_ACL, KIND_ISO: begin
        hdr_done   = (rcv_nxt == CNT_W'(4));
        len        = LEN_W'(4) + LEN_W'({in_rx_byte, hold_r[2]});
        burst_last = IDX_W'(3);
      end
      default: begin
        hdr_done   = 1'b0;
        len        = '0;
        burst_last = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    need_nxt    = need_r;
    swallow_nxt = swallow_r;
    done        = 1'b0;
    push        = 1'b0;
    push_data   = '0;
    push_data.kind = kind_r;
    case (phase_r)
      PH_HUNT: begin
        if (acc && in_rx_byte >= DATA_W'(KIND_CMD) && in_rx_byte <= DATA_W'(KIND_ISO)) begin
          kind_nxt    = in_rx_byte[KIND_W-1:0];
          swallow_nxt = 1'b0;
          need_nxt    = '0;
          phase_nxt   = PH_HDR;
        end
      end
      PH_HDR: begin
        if (acc && hdr_done) begin
          if (len > LEN_W'(MAX_FRAME)) begin
            phase_nxt = PH_HUNT;
          end else begin
            done      = LEN_W'(rcv_nxt) >= len;
            need_nxt  = len[CNT_W-1:0];
            phase_nxt = done ? PH_HUNT : PH_BODY;
            if (len > LEN_W'(max_deliver)) begin
              swallow_nxt = 1'b1;
            end else begin
              push               = 1'b1;
              push_data.length   = len[FLEN_W-1:0];
              push_data.last_idx = burst_last;
              push_data.first    = 1'b1;
              push_data.last     = done;
              push_data.bytes[0] = hold_r[0];
              push_data.bytes[1] = (kind_r == KIND_EVT) ? in_rx_byte : hold_r[1];
              push_data.bytes[2] = (kind_r == KIND_CMD || kind_r == KIND_SCO) ?
                                   in_rx_byte : hold_r[2];
              push_data.bytes[3] = in_rx_byte;
            end
            if (done) begin
              need_nxt    = '0;
              swallow_nxt = 1'b0;
            end
          end
        end
      end
      PH_BODY: begin
        if (acc) begin
          done               = rcv_nxt >= need_r;
          push               = !swallow_r;
          push_data.length   = need_ext[FLEN_W-1:0];
          push_data.last_idx = '0;
          push_data.first    = 1'b0;
          push_data.last     = done;
          push_data.bytes[0] = in_rx_byte;
          if (done) begin
            phase_nxt   = PH_HUNT;
            need_nxt    = '0;
            swallow_nxt = 1'b0;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      kind_r    <= '0;
      rcv_r     <= '0;
      need_r    <= '0;
      swallow_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      need_r    <= need_nxt;
      swallow_r <= swallow_nxt;
      if (phase_r == PH_HUNT) begin
        rcv_r <= '0;
      end else if (acc) begin
        rcv_r <= rcv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_HDR && rcv_r < CNT_W'(3)) begin
      hold_r[rcv_r[1:0]] <= in_rx_byte;
    end
  end

  `ASSERT_CLK(a_hdr_count, clk, rst_n, (phase_r == PH_HDR) |-> (rcv_r <= CNT_W'(3)), "header count overrun")
  `ASSERT_CLK(a_hunt_clean, clk, rst_n, (phase_r == PH_HUNT) |-> (need_r == '0 && !swallow_r), "hunting with frame state left")

endmodule

>>> hdl/h4dfr_queue.sv
// Short FIFO of deframer entries between the front and back ends.
// Depends on h4dfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h4dfr_queue import h4dfr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_CLK(a_cnt_max, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "queue count missed a push")

endmodule

>>> hdl/h4dfr_back.sv
// Back end of the H4 deframer: unpacks queue entries into one output
// transfer per byte with first and last marks. Depends on h4dfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h4dfr_back import h4dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  entry_t            head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_frame_kind,
  output logic [DATA_W-1:0] out_frame_byte,
  output logic              out_first_of_frame,
  output logic              out_last_of_frame,
  output logic [FLEN_W-1:0] out_frame_length
);

  entry_t           cur_r;
  logic             cur_vld_r;
  logic [IDX_W-1:0] idx_r;
  logic             at_last;
  logic             xfer;

  assign at_last = (idx_r == cur_r.last_idx);
  assign xfer    = cur_vld_r && out_ready;
  assign pop     = !empty && (!cur_vld_r || (xfer && at_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (pop) begin
      cur_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (xfer) begin
      if (at_last) begin
        cur_vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  assign out_valid          = cur_vld_r;
  assign out_frame_kind     = cur_r.kind;
  assign out_frame_byte     = cur_r.bytes[idx_r];
  assign out_first_of_frame = cur_r.first && (idx_r == '0);
  assign out_last_of_frame  = cur_r.last && at_last;
  assign out_frame_length   = cur_r.length;

  `ASSERT_CLK(a_idx_range, clk, rst_n, cur_vld_r |-> (idx_r <= cur_r.last_idx), "burst index past entry end")

endmodule

>>> hdl/hci_uart_h4_deframer.sv
// H4 UART deframer top level: max_deliver register on an APB-style port,
// front end, entry queue and back end. Depends on h4dfr_pkg and submodules.
//
// Takes one received byte per cycle whenever in_ready is high and emits the
// frame bytes (indicator stripped) one transfer per cycle while out_ready is
// high. Unless the frame is longer than max_deliver or MAX_FRAME, a byte that
// completes a header produces a burst of 2 to 4 transfers and every payload
// byte produces one. in_ready drops only when the QUEUE_DEPTH-entry queue
// between the parser and the output stage is full; with out_ready held high
// the queue never holds more than four entries, so the input sustains one
// byte per cycle. Write max_deliver only while no frame is in progress.
`timescale 1ns / 1ps

module hci_uart_h4_deframer import h4dfr_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_frame_kind,
  output logic [DATA_W-1:0]  out_frame_byte,
  output logic               out_first_of_frame,
  output logic               out_last_of_frame,
  output logic [FLEN_W-1:0]  out_frame_length
);

  logic [CFG_W-1:0] max_deliver_r;
  logic             push, pop, full, empty;
  entry_t           push_data, head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_DELIVER) ? PDATA_W'(max_deliver_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_deliver_r <= MAX_DELIVER_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_DELIVER) begin
      max_deliver_r <= pwdata[CFG_W-1:0];
    end
  end

  h4dfr_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .max_deliver (max_deliver_r),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  h4dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  h4dfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_kind     (out_frame_kind),
    .out_frame_byte     (out_frame_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_frame_length   (out_frame_length)
  );

endmodule

>>> sim/tb_hci_uart_h4_deframer.sv
// Self-checking testbench for the H4 UART deframer: byte-level predictor in a
// small class, random and directed frame traffic, APB writes of max_deliver.
// Depends on h4dfr_pkg and the hci_uart_h4_deframer RTL.
`timescale 1ns / 1ps

module tb_hci_uart_h4_deframer;
  import h4dfr_pkg::*;

  localparam int MAX_LEN       = MAX_FRAME_DEF;
  localparam int SETTLE_CYCLES = 10;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic              is_first;
    logic              is_last;
    logic [FLEN_W-1:0] length;
  } frame_out_t;

  class frame_byte_predictor;
    logic [KIND_W-1:0] kind;
    logic [FLEN_W-1:0] rcvd;
    logic [FLEN_W-1:0] need;
    logic [DATA_W-1:0] hold [3];
    bit                swallow;
    logic [CFG_W-1:0]  deliver_max;
    frame_out_t        expected_bytes [$];
    int                mismatches;

    function new();
      deliver_max = MAX_DELIVER_RST;
      mismatches  = 0;
      clear();
    endfunction

    function void clear();
      kind    = KIND_NONE;
      rcvd    = '0;
      need    = '0;
      swallow = 1'b0;
      for (int i = 0; i < 3; i++) hold[i] = '0;
    endfunction

    function bit busy();
      return kind != KIND_NONE;
    endfunction

    function void add(logic [DATA_W-1:0] b, bit f, bit l);
      frame_out_t r;
      r.kind     = kind;
      r.data     = b;
      r.is_first = f;
      r.is_last  = l;
      r.length   = need;
      expected_bytes.push_back(r);
    endfunction

    function void take_rx_byte(logic [DATA_W-1:0] b);
      logic [LEN_W-1:0] len;
      bit done;
      if (kind == KIND_NONE) begin
        if (b >= {5'd0, KIND_CMD} && b <= {5'd0, KIND_ISO}) begin
          kind    = b[KIND_W-1:0];
          rcvd    = '0;
          need    = '0;
          swallow = 1'b0;
        end
        return;
      end
      if (rcvd < 3) hold[rcvd[1:0]] = b;
      if (rcvd < MAX_LEN) rcvd++;
      if (need == 0) begin
        len = '0;
        if ((kind == KIND_CMD || kind == KIND_SCO) && rcvd == 3)
          len = LEN_W'(3) + LEN_W'(b);
        else if (kind == KIND_EVT && rcvd == 2)
          len = LEN_W'(2) + LEN_W'(b);
        else if ((kind == KIND_ACL || kind == KIND_ISO) && rcvd == 4)
          len = LEN_W'(4) + LEN_W'({b, hold[2]});
        if (len == 0) return;
        if (len > MAX_LEN) begin
          clear();
          return;
        end
        need = len[FLEN_W-1:0];
        if (len > deliver_max) begin
          swallow = 1'b1;
        end else begin
          done = rcvd >= need;
          for (int i = 0; i + 1 < rcvd && i < 3; i++) add(hold[i], i == 0, 1'b0);
          add(b, 1'b0, done);
        end
        if (rcvd >= need) clear();
        return;
      end
      done = rcvd >= need;
      if (!swallow) add(b, 1'b0, done);
      if (done) clear();
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame_byte(frame_out_t got);
      frame_out_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte 0x%02h", got.data);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      cmp("frame_kind", want.kind, got.kind);
      cmp("frame_byte", want.data, got.data);
      cmp("first_of_frame", want.is_first, got.is_first);
      cmp("last_of_frame", want.is_last, got.is_last);
      cmp("frame_length", want.length, got.length);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [DATA_W-1:0]  in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  out_frame_kind;
  logic [DATA_W-1:0]  out_frame_byte;
  logic               out_first_of_frame;
  logic               out_last_of_frame;
  logic [FLEN_W-1:0]  out_frame_length;

  frame_byte_predictor tracker = new();
  int  calm_in = 0;
  int  calm_out = 0;
  int  rx_stall = 0;
  int  idle_cycles = 0;
  int  frame_items = 0;
  bit  hold_req = 1'b0;

  hci_uart_h4_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_kind    (out_frame_kind),
    .out_frame_byte    (out_frame_byte),
    .out_first_of_frame(out_first_of_frame),
    .out_last_of_frame (out_last_of_frame),
    .out_frame_length  (out_frame_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    frame_out_t got;
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got.kind     = out_frame_kind;
        got.data     = out_frame_byte;
        got.is_first = out_first_of_frame;
        got.is_last  = out_last_of_frame;
        got.length   = out_frame_length;
        tracker.check_frame_byte(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  function automatic int idle_len(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
      rx_stall = idle_len(calm_out);
    end
  end

  // called at a falling edge once the previous transfer is done
  task automatic send_byte(input logic [DATA_W-1:0] b);
    int gap;
    gap = idle_len(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_deliver(input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_DELIVER;
    pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.deliver_max = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [KIND_W-1:0] random_kind();
    case ($urandom_range(0, 4))
      0: return KIND_CMD;
      1: return KIND_ACL;
      2: return KIND_SCO;
      3: return KIND_EVT;
      default: return KIND_ISO;
    endcase
  endfunction

  function automatic int unsigned pick_payload(logic [KIND_W-1:0] kind);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 8);
    if (kind == KIND_ACL || kind == KIND_ISO) begin
      if (r < 93) return $urandom_range(9, 60);
      if (r < 97) return $urandom_range(61, 300);
      return $urandom_range(MAX_LEN - 3, 65535);
    end
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 255);
  endfunction

  // plen: payload length; for any kind, above MAX_LEN-4 only the header goes out
  task automatic send_frame(input logic [KIND_W-1:0] kind, input int unsigned plen);
    logic [15:0] lf;
    lf = plen[15:0];
    send_byte({5'd0, kind});
    send_byte(DATA_W'($urandom_range(0, 255)));
    if (kind != KIND_EVT) send_byte(DATA_W'($urandom_range(0, 255)));
    send_byte(lf[7:0]);
    if (kind == KIND_ACL || kind == KIND_ISO) send_byte(lf[15:8]);
    frame_items += 4;
    if (4 + plen <= MAX_LEN) begin
      repeat (plen) send_byte(DATA_W'($urandom_range(0, 255)));
      frame_items += plen;
    end
  endtask

  task automatic finish_frame();
    while (tracker.busy()) send_byte(8'h00);
  endtask

  task automatic run_traffic(input int budget);
    int r;
    logic [KIND_W-1:0] k;
    frame_items = 0;
    while (frame_items < budget) begin
      r = $urandom_range(0, 99);
      k = random_kind();
      if (r < 85) begin
        send_frame(k, pick_payload(k));
      end else if (r < 93) begin
        send_byte(DATA_W'($urandom_range(0, 255)));
      end else begin
        // truncated frame: indicator and up to three more random bytes
        send_byte({5'd0, k});
        repeat ($urandom_range(0, 3)) send_byte(DATA_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic next_phase(input logic [CFG_W-1:0] v);
    finish_frame();
    wait_drained();
    write_max_deliver(v);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h06);
    send_frame(KIND_EVT, 0);
    send_frame(KIND_CMD, 1);
    send_frame(KIND_SCO, 0);
    send_frame(KIND_ACL, 1);
    send_frame(KIND_ISO, 16'hFFFF);
    send_frame(KIND_ACL, MAX_LEN - 3);

    next_phase(16'd4);
    send_frame(KIND_CMD, 2);
    send_frame(KIND_EVT, 2);

    next_phase(16'hFFFF);
    hold_req = 1'b1;
    run_traffic(45);
    wait_drained();
    run_traffic(35);

    next_phase(16'd0);
    run_traffic(35);

    next_phase(CFG_W'($urandom_range(1, 1100)));
    run_traffic(55);

    next_phase(16'd40);
    run_traffic(55);

    next_phase(MAX_DELIVER_RST);
    run_traffic(40);

    wait_drained();
    repeat (20) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
